>>> src/rbsi_pkg.sv
// shared constants for the ray/box slab intersection block
package rbsi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int DIST_WIDTH      = 31;
   localparam int NUM_AXES        = 3;

   // bound selection inside one slab
   localparam int BOUND_LO = 0;
   localparam int BOUND_HI = 1;

endpackage

>>> src/ray_box_slab_intersection.sv
// ray versus axis-aligned box slab test, fully pipelined
//
// One word is a ray (origin, direction) and a box (min/max per axis), all
// signed fixed point with FRAC_BITS fraction bits. It is taken at a rising
// edge with start high and busy low. busy is high only while reset is held,
// so a word can be taken in every cycle.
// Each word yields one result word: done is high for exactly one cycle with
// rsp_hit and rsp_distance valid; the receiver cannot stall the block.
// Throughput is one word per cycle. The pipeline holds the input and setup
// stages, the six restoring dividers, each producing one quotient bit per
// stage over COORD_WIDTH + FRAC_BITS + 1 stages, and saturation, ordering
// and two clipping stages.
// Reset clears every valid bit; words in flight are dropped.
module ray_box_slab_intersection #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]         req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]         req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]         req_dir_x,
   input  logic signed [COORD_WIDTH-1:0]         req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]         req_dir_z,
   input  logic signed [COORD_WIDTH-1:0]         req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0]         req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0]         req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0]         req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0]         req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0]         req_box_max_z,
   output logic                                  done,
   output logic                                  rsp_hit,
   output logic [rbsi_pkg::DIST_WIDTH-1:0]       rsp_distance
);
   import rbsi_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int NB  = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int LAT = NB + 6;
   localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [NB-1:0] LIM_POS = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NB-1:0] LIM_NEG = {{(NB-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   // input register
   logic                v0_ff;
   logic signed [W-1:0] o_ff  [NUM_AXES];
   logic signed [W-1:0] d_ff  [NUM_AXES];
   logic signed [W-1:0] lo_ff [NUM_AXES];
   logic signed [W-1:0] hi_ff [NUM_AXES];

   // divider pipeline, index 0 is the setup stage
   logic          vd_ff  [NB+1];
   logic [W-1:0]  rem_ff [NUM_AXES][2][NB+1];
   logic [NB-1:0] quo_ff [NUM_AXES][2][NB+1];
   logic          neg_ff [NUM_AXES][2][NB+1];
   logic [W-1:0]  dm_ff  [NUM_AXES][NB+1];
   logic          zr_ff  [NUM_AXES][NB+1];
   logic          ok_ff  [NUM_AXES][NB+1];

   // post stages
   logic                vp1_ff, vp2_ff, vp3_ff;
   logic signed [W-1:0] t_ff   [NUM_AXES][2];
   logic                okp1_ff [NUM_AXES];
   logic signed [W-1:0] en_ff  [NUM_AXES];
   logic signed [W-1:0] lv_ff  [NUM_AXES];
   logic                okp2_ff [NUM_AXES];
   logic signed [W-1:0] c0_ff, c1_ff, e2_ff, l2_ff;
   logic                hit01_ff;

   logic                   done_ff;
   logic                   hit_ff;
   logic [DIST_WIDTH-1:0]  dist_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      o_ff[0]  <= req_origin_x;
      o_ff[1]  <= req_origin_y;
      o_ff[2]  <= req_origin_z;
      d_ff[0]  <= req_dir_x;
      d_ff[1]  <= req_dir_y;
      d_ff[2]  <= req_dir_z;
      lo_ff[0] <= req_box_min_x;
      hi_ff[0] <= req_box_max_x;
      lo_ff[1] <= req_box_min_y;
      hi_ff[1] <= req_box_max_y;
      lo_ff[2] <= req_box_min_z;
      hi_ff[2] <= req_box_max_z;
   end

   // valid chain through the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NB; k++) vd_ff[k] <= 1'b0;
      end else begin
         vd_ff[0] <= v0_ff;
         for (int k = 1; k <= NB; k++) vd_ff[k] <= vd_ff[k-1];
      end
   end

   genvar a, b, k;
   generate
      for (a = 0; a < NUM_AXES; a++) begin : g_axis
         logic [W-1:0]        dm_in;
         logic signed [W-1:0] mn_in, mx_in;
         logic                ok_in;

         always_comb begin
            dm_in = d_ff[a][W-1] ? W'(-d_ff[a]) : W'(d_ff[a]);
            mn_in = (lo_ff[a] < hi_ff[a]) ? lo_ff[a] : hi_ff[a];
            mx_in = (lo_ff[a] < hi_ff[a]) ? hi_ff[a] : lo_ff[a];
            ok_in = (d_ff[a] != '0) || !(o_ff[a] < mn_in || o_ff[a] > mx_in);
         end

         always_ff @(posedge clock) begin
            dm_ff[a][0] <= dm_in;
            zr_ff[a][0] <= (d_ff[a] == '0);
            ok_ff[a][0] <= ok_in;
         end

         for (k = 1; k <= NB; k++) begin : g_carry
            always_ff @(posedge clock) begin
               dm_ff[a][k] <= dm_ff[a][k-1];
               zr_ff[a][k] <= zr_ff[a][k-1];
               ok_ff[a][k] <= ok_ff[a][k-1];
            end
         end

         for (b = 0; b < 2; b++) begin : g_bound
            logic signed [W:0] diff_in;
            logic [W:0]        nm_in;

            always_comb begin
               diff_in = (b == BOUND_HI)
                       ? ({hi_ff[a][W-1], hi_ff[a]} - {o_ff[a][W-1], o_ff[a]})
                       : ({lo_ff[a][W-1], lo_ff[a]} - {o_ff[a][W-1], o_ff[a]});
               nm_in   = diff_in[W] ? (W+1)'(-diff_in) : (W+1)'(diff_in);
            end

            always_ff @(posedge clock) begin
               rem_ff[a][b][0] <= '0;
               quo_ff[a][b][0] <= {nm_in, {FRAC_BITS{1'b0}}};
               neg_ff[a][b][0] <= diff_in[W] ^ d_ff[a][W-1];
            end

            for (k = 1; k <= NB; k++) begin : g_step
               logic [W:0]   sh_in;
               logic         bit_in;
               logic [W-1:0] rem_in;

               always_comb begin
                  sh_in  = {rem_ff[a][b][k-1], quo_ff[a][b][k-1][NB-1]};
                  bit_in = (sh_in >= {1'b0, dm_ff[a][k-1]});
                  rem_in = bit_in ? W'(sh_in - {1'b0, dm_ff[a][k-1]}) : sh_in[W-1:0];
               end

               always_ff @(posedge clock) begin
                  rem_ff[a][b][k] <= rem_in;
                  quo_ff[a][b][k] <= {quo_ff[a][b][k-1][NB-2:0], bit_in};
                  neg_ff[a][b][k] <= neg_ff[a][b][k-1];
               end
            end

            // saturate and apply sign
            logic [NB-1:0]       lim_in, qs_in;
            logic signed [W-1:0] t_in;

            always_comb begin
               lim_in = neg_ff[a][b][NB] ? LIM_NEG : LIM_POS;
               qs_in  = (quo_ff[a][b][NB] > lim_in) ? lim_in : quo_ff[a][b][NB];
               if (zr_ff[a][NB]) begin
                  t_in = (b == BOUND_HI) ? T_MAX : T_MIN;
               end else if (neg_ff[a][b][NB]) begin
                  t_in = W'(-qs_in[W-1:0]);
               end else begin
                  t_in = qs_in[W-1:0];
               end
            end

            always_ff @(posedge clock) begin
               t_ff[a][b] <= t_in;
            end
         end

         always_ff @(posedge clock) begin
            okp1_ff[a] <= ok_ff[a][NB];
            en_ff[a]   <= (t_ff[a][0] < t_ff[a][1]) ? t_ff[a][0] : t_ff[a][1];
            lv_ff[a]   <= (t_ff[a][0] < t_ff[a][1]) ? t_ff[a][1] : t_ff[a][0];
            okp2_ff[a] <= okp1_ff[a];
         end
      end
   endgenerate

   // clip x with y, then with z and choose the distance
   logic                    hit_in;
   logic signed [W-1:0]     f0_in, f1_in, dsel_in;
   logic [W+DIST_WIDTH-1:0] dext_in;

   always_comb begin
      hit_in  = hit01_ff && !(c0_ff > l2_ff || e2_ff > c1_ff);
      f0_in   = (e2_ff > c0_ff) ? e2_ff : c0_ff;
      f1_in   = (l2_ff < c1_ff) ? l2_ff : c1_ff;
      dsel_in = '0;
      if (hit_in) begin
         if (f0_in > 0) begin
            dsel_in = f0_in;
         end else if (f1_in > 0) begin
            dsel_in = f1_in;
         end else begin
            hit_in = 1'b0;
         end
      end
      dext_in = {{DIST_WIDTH{1'b0}}, dsel_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp1_ff  <= 1'b0;
         vp2_ff  <= 1'b0;
         vp3_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         vp1_ff  <= vd_ff[NB];
         vp2_ff  <= vp1_ff;
         vp3_ff  <= vp2_ff;
         done_ff <= vp3_ff;
      end
      hit01_ff <= okp2_ff[0] && okp2_ff[1] && okp2_ff[2]
                  && !(en_ff[0] > lv_ff[1] || en_ff[1] > lv_ff[0]);
      c0_ff    <= (en_ff[1] > en_ff[0]) ? en_ff[1] : en_ff[0];
      c1_ff    <= (lv_ff[1] < lv_ff[0]) ? lv_ff[1] : lv_ff[0];
      e2_ff    <= en_ff[2];
      l2_ff    <= lv_ff[2];
      hit_ff   <= hit_in;
      dist_ff  <= dext_in[DIST_WIDTH-1:0];
   end

   assign done         = done_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_distance = dist_ff;

`ifndef NO_ASSERTIONS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##(LAT-1) done)
      else $error("accepted word produced no result");
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      done |-> $past(vp3_ff))
      else $error("result without word in flight");
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (done && !rsp_hit) |-> (rsp_distance == '0))
      else $error("miss with nonzero distance");
   a_hit_pos : assert property (@(posedge clock) disable iff (reset)
      (done && rsp_hit) |-> (rsp_distance != '0))
      else $error("hit at zero distance");
`endif

endmodule

>>> bench/tb_ray_box_slab_intersection.sv
// testbench for the ray/box slab intersection block: random and directed rays against a predictor
module tb_ray_box_slab_intersection;
   timeunit 1ns;
   timeprecision 1ps;

   import rbsi_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int NUM_RANDOM = 1530;
   localparam int LATENCY = CW + FB + 7;
   localparam longint T_MAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint T_MIN = -(64'sd1 <<< (CW - 1));

   typedef struct {
      logic signed [CW-1:0] org [NUM_AXES];
      logic signed [CW-1:0] dir [NUM_AXES];
      logic signed [CW-1:0] lo [NUM_AXES];
      logic signed [CW-1:0] hi [NUM_AXES];
      int gap;
   } ray_box_type;

   typedef struct {
      logic hit;
      logic [DIST_WIDTH-1:0] distance;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy, done, rsp_hit;
   logic [DIST_WIDTH-1:0] rsp_distance;
   logic signed [CW-1:0] org_q [NUM_AXES];
   logic signed [CW-1:0] dir_q [NUM_AXES];
   logic signed [CW-1:0] lo_q [NUM_AXES];
   logic signed [CW-1:0] hi_q [NUM_AXES];

   ray_box_type pending_rays [$];
   hit_type expected_hits [$];
   int mismatches = 0;
   int gap_left = 0;
   bit stim_done = 0;
   ray_box_type cur;
   bit have_cur = 0;

   always #4 clock = ~clock;

   ray_box_slab_intersection DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_origin_x(org_q[0]), .req_origin_y(org_q[1]), .req_origin_z(org_q[2]),
      .req_dir_x(dir_q[0]), .req_dir_y(dir_q[1]), .req_dir_z(dir_q[2]),
      .req_box_min_x(lo_q[0]), .req_box_max_x(hi_q[0]),
      .req_box_min_y(lo_q[1]), .req_box_max_y(hi_q[1]),
      .req_box_min_z(lo_q[2]), .req_box_max_z(hi_q[2]),
      .done(done), .rsp_hit(rsp_hit), .rsp_distance(rsp_distance)
   );

   function automatic void add_ray(ray_box_type rb);
      pending_rays.insert(pending_rays.size(), rb);
   endfunction

   function automatic longint slab_quotient(longint a, longint b, longint d);
      longint num, dm, lim, q, r;
      bit neg;
      num = a - b;
      neg = (num < 0) != (d < 0);
      if (num < 0) num = -num;
      dm = d < 0 ? -d : d;
      lim = neg ? -T_MIN : T_MAX;
      q = num / dm;
      r = num % dm;
      if (q > lim) q = lim;
      else
         for (int i = 0; i < FB; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= dm) begin
               r = r - dm;
               q = q | 1;
            end
            if (q > lim) begin
               q = lim;
               break;
            end
         end
      return neg ? -q : q;
   endfunction

   function automatic hit_type predict_hit(ray_box_type rb);
      hit_type res;
      longint t0, t1, e, l, a, b, o, mn, mx;
      bit hit;
      t0 = 0;
      t1 = 0;
      hit = 1;
      for (int ax = 0; ax < NUM_AXES && hit; ax++) begin
         o = rb.org[ax];
         if (rb.dir[ax] == 0) begin
            mn = rb.lo[ax] < rb.hi[ax] ? rb.lo[ax] : rb.hi[ax];
            mx = rb.lo[ax] < rb.hi[ax] ? rb.hi[ax] : rb.lo[ax];
            if (o < mn || o > mx) begin
               hit = 0;
               continue;
            end
            e = T_MIN;
            l = T_MAX;
         end else begin
            a = slab_quotient(rb.lo[ax], o, rb.dir[ax]);
            b = slab_quotient(rb.hi[ax], o, rb.dir[ax]);
            e = a < b ? a : b;
            l = a < b ? b : a;
         end
         if (ax == 0) begin
            t0 = e;
            t1 = l;
         end else if (t0 > l || e > t1) hit = 0;
         else begin
            if (e > t0) t0 = e;
            if (l < t1) t1 = l;
         end
      end
      res.hit = 0;
      res.distance = '0;
      if (hit) begin
         if (t0 > 0) begin
            res.hit = 1;
            res.distance = t0[DIST_WIDTH-1:0];
         end else if (t1 > 0) begin
            res.hit = 1;
            res.distance = t1[DIST_WIDTH-1:0];
         end
      end
      return res;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord(int kind);
      case (kind)
         0: return $urandom;
         1: return CW'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
         2: return CW'($signed($urandom_range(0, 6)) - 3) <<< FB;
         3: return $urandom_range(0, 1) ? T_MAX[CW-1:0] : T_MIN[CW-1:0];
         default: return CW'($signed($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   function automatic ray_box_type random_ray();
      ray_box_type rb;
      int kind;
      kind = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 4);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         rb.org[ax] = rand_coord($urandom_range(0, 9) < 8 ? kind : $urandom_range(0, 4));
         rb.dir[ax] = $urandom_range(0, 9) == 0 ? '0 :
            rand_coord($urandom_range(0, 9) < 7 ? kind : $urandom_range(0, 4));
         rb.lo[ax] = rand_coord($urandom_range(0, 9) < 8 ? kind : $urandom_range(0, 4));
         rb.hi[ax] = $urandom_range(0, 9) < 8 ? rb.lo[ax] + CW'($urandom_range(0, 8 << FB))
                                              : rand_coord($urandom_range(0, 4));
      end
      rb.gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      return rb;
   endfunction

   function automatic ray_box_type axis_ray(logic signed [CW-1:0] o, logic signed [CW-1:0] d,
                                            logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
      ray_box_type rb;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         rb.org[ax] = o;
         rb.dir[ax] = d;
         rb.lo[ax] = lo;
         rb.hi[ax] = hi;
      end
      rb.gap = 0;
      return rb;
   endfunction

   initial begin
      ray_box_type rb;
      localparam logic signed [CW-1:0] ONE = 1 << FB;
      localparam logic signed [CW-1:0] MX = T_MAX[CW-1:0];
      localparam logic signed [CW-1:0] MN = T_MIN[CW-1:0];
      add_ray(axis_ray(-5 * ONE, ONE, -ONE, ONE));
      add_ray(axis_ray(0, ONE, -ONE, ONE));
      add_ray(axis_ray(5 * ONE, ONE, -ONE, ONE));
      add_ray(axis_ray(-ONE, ONE, ONE, -ONE));
      add_ray(axis_ray(0, 0, -ONE, ONE));
      add_ray(axis_ray(2 * ONE, 0, -ONE, ONE));
      add_ray(axis_ray(ONE, 0, ONE, ONE));
      add_ray(axis_ray(0, ONE, 0, 0));
      add_ray(axis_ray(MN, 1, MN, MX));
      add_ray(axis_ray(MX, -1, MN, MX));
      add_ray(axis_ray(MN, MN, MX, MN));
      add_ray(axis_ray(MX, MX, MN, MX));
      add_ray(axis_ray(MN, MX, MX, MX));
      add_ray(axis_ray(0, -1, MN, MN));
      add_ray(axis_ray(-ONE, -ONE, ONE, 2 * ONE));
      rb = axis_ray(-2 * ONE, ONE, -ONE, ONE);
      rb.org[1] = 0;
      rb.dir[1] = ONE;
      rb.lo[1] = 2 * ONE;
      rb.hi[1] = 3 * ONE;
      add_ray(rb);
      rb.lo[1] = ONE;
      add_ray(rb);
      rb = axis_ray(-3 * ONE, ONE, -ONE, ONE);
      rb.dir[2] = 2 * ONE;
      rb.org[2] = -ONE;
      add_ray(rb);
      for (int i = 0; i < NUM_RANDOM; i++) add_ray(random_ray());
   end

   // driver: one word per start, gap drawn per word
   always @(negedge clock) begin
      if (reset) start <= 1'b0;
      else begin
         if (start && !busy) have_cur = 0;
         if (!have_cur && pending_rays.size() > 0) begin
            cur = pending_rays.pop_front();
            have_cur = 1;
            gap_left = cur.gap;
         end
         if (have_cur && gap_left == 0) begin
            start <= 1'b1;
            org_q <= cur.org;
            dir_q <= cur.dir;
            lo_q <= cur.lo;
            hi_q <= cur.hi;
         end else begin
            start <= 1'b0;
            if (have_cur) gap_left--;
            else if (!stim_done && pending_rays.size() == 0) stim_done = 1;
         end
      end
   end

   // monitor: predict on accept, compare on done
   always @(posedge clock) begin
      ray_box_type acc;
      hit_type want;
      if (!reset) begin
         if (start && !busy) begin
            acc.org = org_q;
            acc.dir = dir_q;
            acc.lo = lo_q;
            acc.hi = hi_q;
            acc.gap = 0;
            expected_hits.insert(expected_hits.size(), predict_hit(acc));
         end
         if (done) begin
            if (expected_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word hit=%0d dist=%0h",
                                              rsp_hit, rsp_distance);
            end else begin
               want = expected_hits.pop_front();
               if (rsp_hit !== want.hit || rsp_distance !== want.distance) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected hit=%0d dist=%0h, got hit=%0d dist=%0h",
                              want.hit, want.distance, rsp_hit, rsp_distance);
               end
            end
         end
      end
   end

   initial begin
      org_q = '{default: '0};
      dir_q = '{default: '0};
      lo_q = '{default: '0};
      hi_q = '{default: '0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_hits.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

endmodule
